[design/cdtl_pkg.sv]
// ----------------------------------------------------------------------------
// CD TOC track lookup package
// Shared entry layout, action codes, TOC constants and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdtl_pkg;

   typedef struct packed {
      logic [7:0] session;
      logic [7:0] control;
      logic [7:0] point;
      logic [7:0] minute;
      logic [7:0] second;
      logic [7:0] frame;
   } toc_entry_type;

   localparam int EntryBits = $bits(toc_entry_type);

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_TRACK  = 2'd1;
   localparam logic [1:0] ACT_SECTOR = 2'd2;

   localparam logic [7:0] PT_LEADOUT   = 8'ha2;
   localparam logic [7:0] PT_FIRSTLAST = 8'ha0;
   localparam logic [7:0] TRACK_LIMIT  = 8'd99;
   localparam int         DATA_BIT     = 2;
   localparam int         Pregap       = 150;
   localparam int         Fps          = 75;
   localparam int         FramesPerMin = 60 * Fps;

   typedef struct packed {
      logic load;    // input beat accepted this cycle
      logic start;   // begin a scan pass over the entries in use
      logic pass2;   // the scan in flight is the second pass
      logic finish;  // result register takes the assembled result
   } cdtl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic two_pass;
      logic rsp_free;
   } cdtl_sts_type;

endpackage

[design/cdtl_req_if.sv]
// ----------------------------------------------------------------------------
// CD TOC request channel
// Valid/ready channel carrying one write or query beat.
// ----------------------------------------------------------------------------
interface cdtl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [6:0]  entry_index;
   logic [7:0]  entry_session;
   logic [7:0]  entry_control;
   logic [7:0]  entry_point;
   logic [7:0]  entry_minute;
   logic [7:0]  entry_second;
   logic [7:0]  entry_frame;
   logic [7:0]  query_track;
   logic        want_end;
   logic [20:0] sector;

   modport source (output valid, action, entry_index, entry_session, entry_control,
                   entry_point, entry_minute, entry_second, entry_frame, query_track,
                   want_end, sector, input ready);
   modport sink (input valid, action, entry_index, entry_session, entry_control,
                 entry_point, entry_minute, entry_second, entry_frame, query_track,
                 want_end, sector, output ready);
endinterface

[design/cdtl_rsp_if.sv]
// ----------------------------------------------------------------------------
// CD TOC response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface cdtl_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] track_number;
   logic [7:0] track_attr;
   logic [7:0] time_minute;
   logic [7:0] time_second;
   logic [7:0] time_frame;
   logic       end_known;
   logic       is_audio;
   logic [7:0] disc_type;
   logic       any_audio;

   modport source (output valid, found, track_number, track_attr, time_minute,
                   time_second, time_frame, end_known, is_audio, disc_type, any_audio,
                   input ready);
   modport sink (input valid, found, track_number, track_attr, time_minute,
                 time_second, time_frame, end_known, is_audio, disc_type, any_audio,
                 output ready);
endinterface

[design/cd_toc_track_lookup.sv]
// ----------------------------------------------------------------------------
// CD TOC track lookup
// Holds a raw CD table of contents and answers track-info and sector
// track-type queries by scanning the stored entries.
//
//   Channel   Dir  Handshake          Beat contents
//   req_chan  in   valid/ready        write entry, track query or sector query
//   rsp_chan  out  valid/ready        one result per request
//   csr_*     in   csr_wr_en          entry_count register
//
// With n entries in use (entry_count capped at MAX_ENTRIES), a write or an
// unused action runs one scan pass over the n entries and a query runs two.
// Scan time is set by the single read port of the entry RAM, which the
// scans walk one entry per cycle. Reset clears control state only; the
// entry RAM holds no reset value. A new request is taken while a finished
// result still waits on rsp_chan.
// ----------------------------------------------------------------------------
module cd_toc_track_lookup #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic       clock,
   input  logic       reset,
   cdtl_req_if.sink   req_chan,
   cdtl_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import cdtl_pkg::*;

   cdtl_cmd_type  cmd;
   cdtl_sts_type  sts;
   toc_entry_type in_entry;

   assign in_entry = '{session: req_chan.entry_session, control: req_chan.entry_control,
                       point: req_chan.entry_point, minute: req_chan.entry_minute,
                       second: req_chan.entry_second, frame: req_chan.entry_frame};

   cdtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdtl_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .in_action        (req_chan.action),
      .in_index         (req_chan.entry_index),
      .in_entry         (in_entry),
      .in_track         (req_chan.query_track),
      .in_want_end      (req_chan.want_end),
      .in_sector        (req_chan.sector),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_found        (rsp_chan.found),
      .rsp_track_number (rsp_chan.track_number),
      .rsp_track_attr   (rsp_chan.track_attr),
      .rsp_time_minute  (rsp_chan.time_minute),
      .rsp_time_second  (rsp_chan.time_second),
      .rsp_time_frame   (rsp_chan.time_frame),
      .rsp_end_known    (rsp_chan.end_known),
      .rsp_is_audio     (rsp_chan.is_audio),
      .rsp_disc_type    (rsp_chan.disc_type),
      .rsp_any_audio    (rsp_chan.any_audio)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a previous one is in progress");

   a_end_needs_track: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_known |-> rsp_chan.found)
      else $error("end time reported for a track that was not found");

   a_audio_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_audio |->
         rsp_chan.found && !rsp_chan.track_attr[DATA_BIT] && rsp_chan.disc_type == 8'd0)
      else $error("audio result disagrees with track attributes");
endmodule

[design/cdtl_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdtl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/cdtl_ctrl.sv]
// ----------------------------------------------------------------------------
// CD TOC lookup controller
// Sequences the accept, one or two scan passes and the result hand-off.
// ----------------------------------------------------------------------------
module cdtl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdtl_pkg::cdtl_sts_type sts,
   output cdtl_pkg::cdtl_cmd_type cmd
);
   import cdtl_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_P1_START = 6'b000010,
      S_P1_RUN   = 6'b000100,
      S_P2_START = 6'b001000,
      S_P2_RUN   = 6'b010000,
      S_FIN      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_P1_START;
            end
         end
         S_P1_START: begin
            cmd.start = 1'b1;
            state_in  = S_P1_RUN;
         end
         S_P1_RUN: begin
            if (sts.scan_done) begin
               state_in = sts.two_pass ? S_P2_START : S_FIN;
            end
         end
         S_P2_START: begin
            cmd.start = 1'b1;
            cmd.pass2 = 1'b1;
            state_in  = S_P2_RUN;
         end
         S_P2_RUN: begin
            cmd.pass2 = 1'b1;
            if (sts.scan_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[design/cdtl_dp.sv]
// ----------------------------------------------------------------------------
// CD TOC lookup datapath
// Entry RAM, scan counter, per-pass match logic and the result register.
// ----------------------------------------------------------------------------
module cdtl_dp #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cdtl_pkg::cdtl_cmd_type cmd,
   output cdtl_pkg::cdtl_sts_type sts,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic [1:0]             in_action,
   input  logic [6:0]             in_index,
   input  cdtl_pkg::toc_entry_type in_entry,
   input  logic [7:0]             in_track,
   input  logic                   in_want_end,
   input  logic [20:0]            in_sector,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_found,
   output logic [7:0]             rsp_track_number,
   output logic [7:0]             rsp_track_attr,
   output logic [7:0]             rsp_time_minute,
   output logic [7:0]             rsp_time_second,
   output logic [7:0]             rsp_time_frame,
   output logic                   rsp_end_known,
   output logic                   rsp_is_audio,
   output logic [7:0]             rsp_disc_type,
   output logic                   rsp_any_audio
);
   import cdtl_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [7:0]    count_ff;
   logic [CW-1:0] used;
   logic [CW-1:0] addr_ff, addr_in;
   logic          issue_ff, issue_in;
   logic          rd_vld_ff;
   toc_entry_type rd_entry;
   logic          wr_en;

   logic [1:0]  act_ff;
   logic [7:0]  track_ff;
   logic        want_end_ff;
   logic [20:0] sector_ff;

   logic          any_ff, any_in;
   logic          tf_ff, tf_in;
   toc_entry_type t_ff, t_in;
   logic          nf_ff, nf_in;
   toc_entry_type nxt_ff, nxt_in;
   logic          lf_ff, lf_in;
   toc_entry_type lead_ff, lead_in;
   logic          df_ff, df_in;
   logic [7:0]    dtype_ff, dtype_in;
   toc_entry_type prev_ff;
   logic          prev_vld_ff;

   logic [20:0] msf;
   logic        covers;
   logic        in_range;

   logic        rsp_valid_ff;
   logic        found_ff, found_in;
   logic [7:0]  num_ff, num_in, attr_ff, attr_in;
   logic [7:0]  tmin_ff, tmin_in, tsec_ff, tsec_in, tfrm_ff, tfrm_in;
   logic        endk_ff, endk_in, audio_ff, audio_in;
   logic [7:0]  disc_ff, disc_in;
   logic        any_out_ff;

   assign used = ({1'b0, count_ff} > 9'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_ff);
   assign wr_en = cmd.load && (in_action == ACT_WRITE) && (32'(in_index) < MAX_ENTRIES);

   cdtl_ram #(.WIDTH(EntryBits), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(in_index)),
      .wr_data (in_entry),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   // Scan counter: one address per cycle, read data arrives in the cycle after.
   always_comb begin
      addr_in  = addr_ff;
      issue_in = issue_ff;
      if (cmd.start) begin
         addr_in  = '0;
         issue_in = (used != '0);
      end else if (issue_ff) begin
         addr_in  = addr_ff + CW'(1);
         issue_in = (addr_ff + CW'(1)) != used;
      end
   end

   assign msf = 21'(rd_entry.minute) * 21'(FramesPerMin) + 21'(rd_entry.second) * 21'(Fps)
              + 21'(rd_entry.frame);
   assign covers = (rd_entry.point >= 8'd1) && (rd_entry.point <= TRACK_LIMIT)
                && (msf >= 21'(Pregap))
                && ({1'b0, sector_ff} + 22'(Pregap) >= {1'b0, msf});
   assign in_range = (track_ff >= 8'd1) && (track_ff < TRACK_LIMIT);

   always_comb begin
      any_in   = any_ff;
      tf_in    = tf_ff;
      t_in     = t_ff;
      nf_in    = nf_ff;
      nxt_in   = nxt_ff;
      lf_in    = lf_ff;
      lead_in  = lead_ff;
      df_in    = df_ff;
      dtype_in = dtype_ff;
      if (cmd.load) begin
         any_in = 1'b0;
         tf_in  = 1'b0;
         nf_in  = 1'b0;
         lf_in  = 1'b0;
         df_in  = 1'b0;
      end else if (rd_vld_ff && !cmd.pass2) begin
         if (!rd_entry.control[DATA_BIT]) begin
            any_in = 1'b1;
         end
         if (act_ff == ACT_TRACK && !tf_ff && rd_entry.point == track_ff) begin
            tf_in = 1'b1;
            t_in  = rd_entry;
         end
         // The last covering entry wins, so later matches overwrite.
         if (act_ff == ACT_SECTOR && covers) begin
            tf_in = 1'b1;
            t_in  = rd_entry;
         end
      end else if (rd_vld_ff) begin
         if (act_ff == ACT_TRACK) begin
            if (!nf_ff && track_ff < TRACK_LIMIT - 8'd1 && rd_entry.point == track_ff + 8'd1
                && rd_entry.session == t_ff.session) begin
               nf_in  = 1'b1;
               nxt_in = rd_entry;
            end
            if (!lf_ff && rd_entry.point == PT_LEADOUT && rd_entry.session == t_ff.session) begin
               lf_in   = 1'b1;
               lead_in = rd_entry;
            end
         end
         if (act_ff == ACT_SECTOR && prev_vld_ff && !df_ff && prev_ff.point == PT_FIRSTLAST
             && t_ff.point >= prev_ff.minute && t_ff.point <= rd_entry.minute) begin
            df_in    = 1'b1;
            dtype_in = prev_ff.second;
         end
      end
   end

   // Result assembly.
   always_comb begin
      found_in = 1'b0;
      num_in   = '0;
      attr_in  = '0;
      tmin_in  = '0;
      tsec_in  = '0;
      tfrm_in  = '0;
      endk_in  = 1'b0;
      audio_in = 1'b0;
      disc_in  = '0;
      if ((act_ff == ACT_TRACK && tf_ff && in_range) || (act_ff == ACT_SECTOR && tf_ff)) begin
         found_in = 1'b1;
         num_in   = t_ff.point;
         attr_in  = t_ff.control;
      end
      if (act_ff == ACT_TRACK && tf_ff && in_range) begin
         if (!want_end_ff) begin
            tmin_in = t_ff.minute;
            tsec_in = t_ff.second;
            tfrm_in = t_ff.frame;
         end else if (nf_ff) begin
            tmin_in = nxt_ff.minute;
            tsec_in = nxt_ff.second;
            tfrm_in = nxt_ff.frame;
            endk_in = 1'b1;
         end else if (lf_ff) begin
            tmin_in = lead_ff.minute;
            tsec_in = lead_ff.second;
            tfrm_in = lead_ff.frame;
            endk_in = 1'b1;
         end
      end
      if (act_ff == ACT_SECTOR && tf_ff) begin
         audio_in = !t_ff.control[DATA_BIT];
         disc_in  = (t_ff.control[DATA_BIT] && df_ff) ? dtype_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prev_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         issue_ff    <= issue_in;
         rd_vld_ff   <= issue_ff && !cmd.start;
         prev_vld_ff <= cmd.start ? 1'b0 : (prev_vld_ff || rd_vld_ff);
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      any_ff   <= any_in;
      tf_ff    <= tf_in;
      t_ff     <= t_in;
      nf_ff    <= nf_in;
      nxt_ff   <= nxt_in;
      lf_ff    <= lf_in;
      lead_ff  <= lead_in;
      df_ff    <= df_in;
      dtype_ff <= dtype_in;
      if (rd_vld_ff) begin
         prev_ff <= rd_entry;
      end
      if (cmd.load) begin
         act_ff      <= in_action;
         track_ff    <= in_track;
         want_end_ff <= in_want_end;
         sector_ff   <= in_sector;
      end
      if (cmd.finish) begin
         found_ff   <= found_in;
         num_ff     <= num_in;
         attr_ff    <= attr_in;
         tmin_ff    <= tmin_in;
         tsec_ff    <= tsec_in;
         tfrm_ff    <= tfrm_in;
         endk_ff    <= endk_in;
         audio_ff   <= audio_in;
         disc_ff    <= disc_in;
         any_out_ff <= any_ff;
      end
   end

   assign sts.scan_done = !issue_ff && !rd_vld_ff;
   assign sts.two_pass  = (act_ff == ACT_TRACK) || (act_ff == ACT_SECTOR);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_track_number = num_ff;
   assign rsp_track_attr   = attr_ff;
   assign rsp_time_minute  = tmin_ff;
   assign rsp_time_second  = tsec_ff;
   assign rsp_time_frame   = tfrm_ff;
   assign rsp_end_known    = endk_ff;
   assign rsp_is_audio     = audio_ff;
   assign rsp_disc_type    = disc_ff;
   assign rsp_any_audio    = any_out_ff;
endmodule
